// File: design/rsbk_pkg.sv
// Shared types and constants for the record sorter.
// No dependencies; the sorter, chain and cell files import this package.
package rsbk_pkg;

	localparam int MAX_RECORDS = 64;

	typedef struct packed {
		logic [5:0] tag;
		logic [7:0] weight_kg;
		logic [7:0] height_cm;
	} rec_t;

	// What one cell shows its neighbours
	typedef struct packed {
		logic valid;
		logic gt;     // held key strictly above the incoming key
		rec_t rec;
	} link_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	localparam logic KEY_HEIGHT = 1'b0;
	localparam logic KEY_WEIGHT = 1'b1;

	function automatic logic [7:0] key_of(input rec_t r, input logic sel);
		logic [7:0] k;
		begin
			k = (sel == KEY_WEIGHT) ? r.weight_kg : r.height_cm;
			return k;
		end
	endfunction

endpackage

// File: design/rsbk_in_if.sv
// Input record channel: valid/ready plus one record.
// Depends on nothing.
interface rsbk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] height_cm;
	logic [7:0] weight_kg;
	logic [5:0] record_tag;
	logic       last_item;

	modport source (output valid, height_cm, weight_kg, record_tag, last_item, input ready);
	modport sink   (input valid, height_cm, weight_kg, record_tag, last_item, output ready);
endinterface

// File: design/rsbk_out_if.sv
// Sorted result channel: valid/ready plus one emitted record.
// Depends on nothing.
interface rsbk_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_height_cm;
	logic [7:0] out_weight_kg;
	logic [5:0] out_tag;
	logic       out_last;
	logic       overflow;

	modport source (output valid, out_height_cm, out_weight_kg, out_tag, out_last, overflow,
		input ready);
	modport sink   (input valid, out_height_cm, out_weight_kg, out_tag, out_last, overflow,
		output ready);
endinterface

// File: design/rsbk_cfg_if.sv
// Configuration write channel: valid/ready plus the sort key bit.
// Depends on nothing.
interface rsbk_cfg_if;
	logic valid;
	logic ready;
	logic sort_key;

	modport source (output valid, sort_key, input ready);
	modport sink   (input valid, sort_key, output ready);
endinterface

// File: design/record_sort_by_key_unit.sv
// Batch record sorter. Records arrive on "records" one per transfer; the one
// with last_item set closes the batch. Each record is dropped into place in
// two chains of MAX_RECORDS cells, one ordered by height, one by weight, in
// the cycle it is taken. After the closing record the chain chosen by sort_key
// (sampled at that moment) is shifted out of its head cell on "sorted", one
// record per cycle while the sink is ready. No new record is taken during the
// drain. Equal keys leave in arrival order. Records past MAX_RECORDS are
// dropped and overflow is set on every result of that batch. sort_key is
// written through "cfg", which is always ready.
// Depends on rsbk_pkg, the three channel interfaces and rsbk_chain.
module record_sort_by_key_unit (
	input  logic  clk,
	input  logic  arst_n,
	rsbk_in_if.sink    records,
	rsbk_out_if.source sorted,
	rsbk_cfg_if.sink   cfg
);
	import rsbk_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   sort_key_q;
	logic   drain_key_q;
	logic   overflow_q;

	logic   in_xfer;
	logic   out_xfer;
	logic   insert;
	logic   shift;
	logic   done;
	rec_t   new_rec;

	link_t  head_h, head_w, head;
	logic   second_h, second_w, second;
	logic   full_h, full_w;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q <= KEY_HEIGHT;
		end else if (cfg.valid) begin
			sort_key_q <= cfg.sort_key;
		end
	end

	assign new_rec = '{tag: records.record_tag, weight_kg: records.weight_kg,
		height_cm: records.height_cm};

	assign in_xfer  = records.valid && records.ready;
	assign out_xfer = sorted.valid && sorted.ready;
	// both chains hold the same number of records, so either full flag will do
	assign insert   = in_xfer && !full_h;
	assign shift    = out_xfer;
	assign done     = out_xfer && !second;

	rsbk_chain u_chain_h (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_sel      (KEY_HEIGHT),
		.insert       (insert),
		.shift        (shift),
		.new_rec      (new_rec),
		.head         (head_h),
		.second_valid (second_h),
		.full         (full_h)
	);

	rsbk_chain u_chain_w (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_sel      (KEY_WEIGHT),
		.insert       (insert),
		.shift        (shift),
		.new_rec      (new_rec),
		.head         (head_w),
		.second_valid (second_w),
		.full         (full_w)
	);

	assign head   = (drain_key_q == KEY_WEIGHT) ? head_w : head_h;
	assign second = (drain_key_q == KEY_WEIGHT) ? second_w : second_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			drain_key_q <= KEY_HEIGHT;
			overflow_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && records.last_item) begin
				drain_key_q <= sort_key_q;
			end
			if (done) begin
				overflow_q <= 1'b0;
			end else if (in_xfer && full_w) begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		records.ready = 1'b0;
		sorted.valid  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				records.ready = 1'b1;
				if (in_xfer && records.last_item) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				sorted.valid = head.valid;
				if (done) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign sorted.out_height_cm = head.rec.height_cm;
	assign sorted.out_weight_kg = head.rec.weight_kg;
	assign sorted.out_tag       = head.rec.tag;
	assign sorted.out_last      = !second;
	assign sorted.overflow      = overflow_q;

endmodule

// File: design/rsbk_cell.sv
// One cell of the sorted chain: holds a record and its valid bit.
// Depends on rsbk_pkg.
module rsbk_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_sel,
	input  logic           insert,
	input  logic           shift,
	input  rsbk_pkg::rec_t  new_rec,
	input  rsbk_pkg::link_t prev,
	input  rsbk_pkg::link_t next,
	output rsbk_pkg::link_t self
);
	import rsbk_pkg::*;

	logic valid_q;
	rec_t rec_q;
	logic gt;
	logic take_prev;
	logic take_new;

	assign gt        = valid_q && (key_of(rec_q, key_sel) > key_of(new_rec, key_sel));
	// prev greater: everything moves one place right
	assign take_prev = insert && prev.gt;
	// first place whose key is above the new key or that is empty, after an equal-or-lower one
	assign take_new  = insert && !prev.gt && prev.valid && (gt || !valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next.valid;
		end else if (take_prev || take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= next.rec;
		end else if (take_prev) begin
			rec_q <= prev.rec;
		end else if (take_new) begin
			rec_q <= new_rec;
		end
	end

	assign self = '{valid: valid_q, gt: gt, rec: rec_q};

endmodule

// File: design/rsbk_chain.sv
// Row of MAX_RECORDS cells kept in ascending key order.
// Depends on rsbk_pkg and rsbk_cell.
module rsbk_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_sel,
	input  logic           insert,
	input  logic           shift,
	input  rsbk_pkg::rec_t  new_rec,
	output rsbk_pkg::link_t head,
	output logic           second_valid,
	output logic           full
);
	import rsbk_pkg::*;

	link_t links [MAX_RECORDS];

	// left edge acts as a valid entry below every key; right edge is empty
	localparam link_t LEFT_EDGE  = '{valid: 1'b1, gt: 1'b0, rec: '0};
	localparam link_t RIGHT_EDGE = '{valid: 1'b0, gt: 1'b0, rec: '0};

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		link_t prev_l;
		link_t next_l;
		if (i == 0) begin : g_first
			assign prev_l = LEFT_EDGE;
		end else begin : g_mid_l
			assign prev_l = links[i-1];
		end
		if (i == MAX_RECORDS - 1) begin : g_last
			assign next_l = RIGHT_EDGE;
		end else begin : g_mid_r
			assign next_l = links[i+1];
		end
		rsbk_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key_sel (key_sel),
			.insert  (insert),
			.shift   (shift),
			.new_rec (new_rec),
			.prev    (prev_l),
			.next    (next_l),
			.self    (links[i])
		);
	end

	assign head         = links[0];
	assign second_valid = links[1].valid;
	assign full         = links[MAX_RECORDS-1].valid;

endmodule
